// File: rtl/bsa_pkg.sv
package bsa_pkg;

    // Input request fields
    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  process_id;
        logic [2:0]  resource_index;
        logic [15:0] amount;
        logic        last_element;
    } t_req;

    // Result fields
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] sequence_process;
        logic       last_result;
    } t_rsp;

    // Operation codes
    localparam logic [2:0] OP_LOAD_AVAIL = 3'd0;
    localparam logic [2:0] OP_LOAD_ALLOC = 3'd1;
    localparam logic [2:0] OP_LOAD_NEED  = 3'd2;
    localparam logic [2:0] OP_REQUEST    = 3'd3;
    localparam logic [2:0] OP_CHECK      = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_OVER_NEED  = 2'd1;
    localparam logic [1:0] ST_OVER_AVAIL = 2'd2;
    localparam logic [1:0] ST_UNSAFE     = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PROC_COUNT = 1'b0;
    localparam logic CFG_RES_COUNT  = 1'b1;
    localparam int   CFG_DATA_W     = 5;

endpackage

// File: rtl/bsa_tables.sv
// Allocation and need tables: one write port and one registered read port each.
module bsa_tables import bsa_pkg::*; #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic              i_alloc_we,
    input  logic [DATA_W-1:0] i_alloc_wdata,
    input  logic              i_need_we,
    input  logic [DATA_W-1:0] i_need_wdata,
    output logic [DATA_W-1:0] o_alloc_q,
    output logic [DATA_W-1:0] o_need_q
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_alloc_mem [DEPTH];
    logic [DATA_W-1:0] r_need_mem  [DEPTH];

    // Allocation table
    always_ff @(posedge i_clk) begin
        if (i_alloc_we) begin
            r_alloc_mem[i_wr_addr] <= i_alloc_wdata;
        end
        o_alloc_q <= r_alloc_mem[i_rd_addr];
    end

    // Need table
    always_ff @(posedge i_clk) begin
        if (i_need_we) begin
            r_need_mem[i_wr_addr] <= i_need_wdata;
        end
        o_need_q <= r_need_mem[i_rd_addr];
    end

endmodule

// File: rtl/bankers_safety_allocator_top.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------
// request   | start / busy           | i_req (t_req)
// result    | o_valid (strobe)       | o_rsp (t_rsp)
// config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// Loads and non-final request elements are taken in idle and leave busy low. A final element
// goes through the need check, the available check and the grant.
// Scan: a setup step, then repeated passes that visit each process in index order;
// then the safe sequence as results, or, for an unsafe request, a rollback, then a denial.
// Reset is synchronous, active low; counts return to 16 and 8.
// busy holds off requests until the last result; results cannot be stalled.
module bankers_safety_allocator_top import bsa_pkg::*; #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int AMOUNT_WIDTH  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_req                  i_req,
    output logic                  busy,
    output logic                  o_valid,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW  = $clog2(MAX_PROCESSES);
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int CW  = $clog2(MAX_PROCESSES + 1);
    localparam int RCW = $clog2(MAX_RESOURCES + 1);
    localparam int AW  = AMOUNT_WIDTH;
    localparam int WW  = AMOUNT_WIDTH + $clog2(MAX_PROCESSES + 1);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_CHK_RD   = 15'h0002,
        S_CHK_EV   = 15'h0004,
        S_CHK_AV   = 15'h0008,
        S_UPD_RD   = 15'h0010,
        S_UPD_WR   = 15'h0020,
        S_SC_INIT  = 15'h0040,
        S_PICK     = 15'h0080,
        S_NEED_RD  = 15'h0100,
        S_NEED_EV  = 15'h0200,
        S_ALLOC_RD = 15'h0400,
        S_ALLOC_EV = 15'h0800,
        S_ADV      = 15'h1000,
        S_EMIT     = 15'h2000,
        S_DENY     = 15'h4000
    } t_state;

    t_state           r_state;
    logic [4:0]       r_pcount;
    logic [3:0]       r_rcount;
    logic [AW-1:0]    r_avail  [MAX_RESOURCES];
    logic [AW-1:0]    r_reqbuf [MAX_RESOURCES];
    logic [WW-1:0]    r_work   [MAX_RESOURCES];
    logic             r_fin    [MAX_PROCESSES];
    logic [PW-1:0]    r_seq    [MAX_PROCESSES];
    logic [PW-1:0]    r_pid;
    logic [PW-1:0]    r_i;
    logic [PW-1:0]    r_k;
    logic [RW-1:0]    r_j;
    logic [CW-1:0]    r_done;
    logic             r_progress;
    logic             r_undo;
    logic             r_is_req;
    logic [1:0]       r_status;
    logic             r_valid;
    t_rsp             r_rsp;

    logic             accept;
    logic [AW-1:0]    amt;
    logic [PW-1:0]    pid_idx;
    logic [RW-1:0]    ri_idx;
    logic             p_ok;
    logic             r_ok;
    logic [CW-1:0]    np;
    logic [RCW-1:0]   nr;
    logic             i_last;
    logic             j_last;
    logic             k_last;
    logic             over_avail;
    logic [PW-1:0]    row;
    logic [AW-1:0]    req_j;
    logic [AW-1:0]    alloc_q;
    logic [AW-1:0]    need_q;
    logic [PW+RW-1:0] rd_addr;
    logic [PW+RW-1:0] wr_addr;
    logic             alloc_we;
    logic             need_we;
    logic [AW-1:0]    alloc_wdata;
    logic [AW-1:0]    need_wdata;

    // Request decode
    assign accept  = start && (r_state == S_IDLE);
    assign amt     = AW'(i_req.amount);
    assign pid_idx = PW'(i_req.process_id);
    assign ri_idx  = RW'(i_req.resource_index);
    assign p_ok    = 32'(i_req.process_id) < MAX_PROCESSES;
    assign r_ok    = 32'(i_req.resource_index) < MAX_RESOURCES;

    // Counts in use, clamped
    always_comb begin
        if (r_pcount == 5'd0) begin
            np = CW'(1);
        end else if (32'(r_pcount) > MAX_PROCESSES) begin
            np = CW'(MAX_PROCESSES);
        end else begin
            np = CW'(r_pcount);
        end
        if (r_rcount == 4'd0) begin
            nr = RCW'(1);
        end else if (32'(r_rcount) > MAX_RESOURCES) begin
            nr = RCW'(MAX_RESOURCES);
        end else begin
            nr = RCW'(r_rcount);
        end
    end

    assign i_last = (CW'(r_i) + CW'(1)) == np;
    assign k_last = (CW'(r_k) + CW'(1)) == np;
    assign j_last = (RCW'(r_j) + RCW'(1)) == nr;
    assign req_j  = r_reqbuf[r_j];

    // Request against available, resources in use only
    always_comb begin
        over_avail = 1'b0;
        for (int j = 0; j < MAX_RESOURCES; j++) begin
            if (j < 32'(nr) && r_reqbuf[j] > r_avail[j]) begin
                over_avail = 1'b1;
            end
        end
    end

    // Table ports: loads write in idle, grant and rollback write back the row
    assign row         = (r_state == S_SC_INIT || r_state == S_PICK || r_state == S_NEED_RD
                          || r_state == S_NEED_EV || r_state == S_ALLOC_RD
                          || r_state == S_ALLOC_EV || r_state == S_ADV) ? r_i : r_pid;
    assign rd_addr     = {row, r_j};
    assign wr_addr     = (r_state == S_UPD_WR) ? {r_pid, r_j} : {pid_idx, ri_idx};
    assign alloc_we    = (r_state == S_UPD_WR)
                         || (accept && i_req.operation == OP_LOAD_ALLOC && p_ok && r_ok);
    assign need_we     = (r_state == S_UPD_WR)
                         || (accept && i_req.operation == OP_LOAD_NEED && p_ok && r_ok);
    assign alloc_wdata = (r_state != S_UPD_WR) ? amt :
                         (r_undo ? alloc_q - req_j : alloc_q + req_j);
    assign need_wdata  = (r_state != S_UPD_WR) ? amt :
                         (r_undo ? need_q + req_j : need_q - req_j);

    bsa_tables #(
        .ADDR_W (PW + RW),
        .DATA_W (AW)
    ) u_tables (
        .i_clk         (i_clk),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .i_alloc_we    (alloc_we),
        .i_alloc_wdata (alloc_wdata),
        .i_need_we     (need_we),
        .i_need_wdata  (need_wdata),
        .o_alloc_q     (alloc_q),
        .o_need_q      (need_q)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pcount   <= 5'd16;
            r_rcount   <= 4'd8;
            r_valid    <= 1'b0;
            r_progress <= 1'b0;
            r_undo     <= 1'b0;
            r_is_req   <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_done     <= '0;
            for (int j = 0; j < MAX_RESOURCES; j++) begin
                r_avail[j]  <= '0;
                r_reqbuf[j] <= '0;
                r_work[j]   <= '0;
            end
            for (int p = 0; p < MAX_PROCESSES; p++) begin
                r_fin[p] <= 1'b0;
            end
        end else begin
            r_valid <= 1'b0;

            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROC_COUNT: r_pcount <= i_cfg_data[4:0];
                    CFG_RES_COUNT:  r_rcount <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_req.operation)
                            OP_LOAD_AVAIL: begin
                                if (r_ok) r_avail[ri_idx] <= amt;
                            end
                            OP_REQUEST: begin
                                if (r_ok) r_reqbuf[ri_idx] <= amt;
                                if (i_req.last_element) begin
                                    r_is_req <= 1'b1;
                                    r_pid    <= pid_idx;
                                    r_j      <= '0;
                                    if (!p_ok) begin
                                        r_status <= ST_OVER_NEED;
                                        r_state  <= S_DENY;
                                    end else begin
                                        r_state <= S_CHK_RD;
                                    end
                                end
                            end
                            OP_CHECK: begin
                                r_is_req <= 1'b0;
                                r_state  <= S_SC_INIT;
                            end
                            default: ;
                        endcase
                    end
                end

                // Request against need row, one element per read
                S_CHK_RD: r_state <= S_CHK_EV;
                S_CHK_EV: begin
                    if (req_j > need_q) begin
                        r_status <= ST_OVER_NEED;
                        r_state  <= S_DENY;
                    end else if (j_last) begin
                        r_state <= S_CHK_AV;
                    end else begin
                        r_j     <= r_j + RW'(1);
                        r_state <= S_CHK_RD;
                    end
                end

                // Available check, then tentative grant of available units
                S_CHK_AV: begin
                    if (over_avail) begin
                        r_status <= ST_OVER_AVAIL;
                        r_state  <= S_DENY;
                    end else begin
                        for (int j = 0; j < MAX_RESOURCES; j++) begin
                            if (j < 32'(nr)) r_avail[j] <= r_avail[j] - r_reqbuf[j];
                        end
                        r_j     <= '0;
                        r_undo  <= 1'b0;
                        r_state <= S_UPD_RD;
                    end
                end

                // Read-modify-write of the requesting row
                S_UPD_RD: r_state <= S_UPD_WR;
                S_UPD_WR: begin
                    if (j_last) begin
                        if (r_undo) begin
                            r_status <= ST_UNSAFE;
                            r_state  <= S_DENY;
                        end else begin
                            r_state <= S_SC_INIT;
                        end
                    end else begin
                        r_j     <= r_j + RW'(1);
                        r_state <= S_UPD_RD;
                    end
                end

                // Safety scan setup
                S_SC_INIT: begin
                    for (int j = 0; j < MAX_RESOURCES; j++) begin
                        r_work[j] <= WW'(r_avail[j]);
                    end
                    for (int p = 0; p < MAX_PROCESSES; p++) begin
                        r_fin[p] <= 1'b0;
                    end
                    r_i        <= '0;
                    r_done     <= '0;
                    r_progress <= 1'b0;
                    r_state    <= S_PICK;
                end

                S_PICK: begin
                    r_j <= '0;
                    if (r_fin[r_i]) begin
                        r_state <= S_ADV;
                    end else begin
                        r_state <= S_NEED_RD;
                    end
                end

                // Need row against work vector
                S_NEED_RD: r_state <= S_NEED_EV;
                S_NEED_EV: begin
                    if (WW'(need_q) > r_work[r_j]) begin
                        r_state <= S_ADV;
                    end else if (j_last) begin
                        r_j     <= '0;
                        r_state <= S_ALLOC_RD;
                    end else begin
                        r_j     <= r_j + RW'(1);
                        r_state <= S_NEED_RD;
                    end
                end

                // Release the allocation row into the work vector
                S_ALLOC_RD: r_state <= S_ALLOC_EV;
                S_ALLOC_EV: begin
                    r_work[r_j] <= r_work[r_j] + WW'(alloc_q);
                    if (j_last) begin
                        r_fin[r_i]               <= 1'b1;
                        r_seq[r_done[PW-1:0]]    <= r_i;
                        r_done                   <= r_done + CW'(1);
                        r_progress               <= 1'b1;
                        r_state                  <= S_ADV;
                    end else begin
                        r_j     <= r_j + RW'(1);
                        r_state <= S_ALLOC_RD;
                    end
                end

                // Next process, end of pass decides
                S_ADV: begin
                    if (i_last) begin
                        if (r_done == np) begin
                            r_k     <= '0;
                            r_state <= S_EMIT;
                        end else if (!r_progress) begin
                            if (r_is_req) begin
                                for (int j = 0; j < MAX_RESOURCES; j++) begin
                                    if (j < 32'(nr)) r_avail[j] <= r_avail[j] + r_reqbuf[j];
                                end
                                r_j     <= '0;
                                r_undo  <= 1'b1;
                                r_state <= S_UPD_RD;
                            end else begin
                                r_status <= ST_UNSAFE;
                                r_state  <= S_DENY;
                            end
                        end else begin
                            r_i        <= '0;
                            r_progress <= 1'b0;
                            r_state    <= S_PICK;
                        end
                    end else begin
                        r_i     <= r_i + PW'(1);
                        r_state <= S_PICK;
                    end
                end

                // Safe sequence out, one per cycle
                S_EMIT: begin
                    r_valid                <= 1'b1;
                    r_rsp.status           <= ST_OK;
                    r_rsp.sequence_process <= 4'(r_seq[r_k]);
                    r_rsp.last_result      <= k_last;
                    if (k_last) begin
                        if (r_is_req) begin
                            for (int j = 0; j < MAX_RESOURCES; j++) r_reqbuf[j] <= '0;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_k <= r_k + PW'(1);
                    end
                end

                // Single denial result
                S_DENY: begin
                    r_valid                <= 1'b1;
                    r_rsp.status           <= r_status;
                    r_rsp.sequence_process <= 4'd0;
                    r_rsp.last_result      <= 1'b1;
                    if (r_is_req) begin
                        for (int j = 0; j < MAX_RESOURCES; j++) r_reqbuf[j] <= '0;
                    end
                    r_state <= S_IDLE;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// File: test/bankers_safety_allocator_top_tb.sv
module bankers_safety_allocator_top_tb;
    import bsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PROC      = 16;
    localparam int N_RES       = 8;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        t_req       req;
        bit         typed;
        logic [1:0] st;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    t_req                  i_req;
    logic                  busy;
    logic                  o_valid;
    t_rsp                  o_rsp;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Mirror of the allocator state
    logic [4:0]  proc_cnt;
    logic [3:0]  res_cnt;
    logic [15:0] avail_q[N_RES];
    logic [15:0] alloc_q[N_PROC][N_RES];
    logic [15:0] need_q[N_PROC][N_RES];
    logic [15:0] req_buf[N_RES];
    logic [3:0]  safe_seq[N_PROC];

    t_rsp pending_rsp[$];
    t_row dir_rows[$];
    int   mismatches = 0;
    int   idle_cycles = 0;

    bankers_safety_allocator_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int procs_used();
        if (proc_cnt == 0) return 1;
        if (proc_cnt > N_PROC) return N_PROC;
        return proc_cnt;
    endfunction

    function automatic int res_used();
        if (res_cnt == 0) return 1;
        if (res_cnt > N_RES) return N_RES;
        return res_cnt;
    endfunction

    // Repeated index-order passes; fills safe_seq
    function automatic bit scan_safe(int np, int nr);
        logic [31:0] work[N_RES];
        bit          fin[N_PROC];
        int          done;
        bit          progress;
        bit          fits;
        done = 0;
        for (int j = 0; j < N_RES; j++) work[j] = 32'(avail_q[j]);
        for (int i = 0; i < N_PROC; i++) fin[i] = 0;
        while (done < np) begin
            progress = 0;
            for (int i = 0; i < np; i++) begin
                if (!fin[i]) begin
                    fits = 1;
                    for (int j = 0; j < nr; j++)
                        if (32'(need_q[i][j]) > work[j]) fits = 0;
                    if (fits) begin
                        for (int j = 0; j < nr; j++) work[j] += 32'(alloc_q[i][j]);
                        safe_seq[done] = 4'(i);
                        done++;
                        fin[i] = 1;
                        progress = 1;
                    end
                end
            end
            if (!progress) return 0;
        end
        return 1;
    endfunction

    function automatic void push_status(logic [1:0] st);
        pending_rsp.insert(pending_rsp.size(),
                           t_rsp'{status: st, sequence_process: 4'd0, last_result: 1'b1});
    endfunction

    function automatic void push_sequence(int np);
        for (int k = 0; k < np; k++)
            pending_rsp.insert(pending_rsp.size(),
                               t_rsp'{status: ST_OK, sequence_process: safe_seq[k],
                                      last_result: (k == np - 1)});
    endfunction

    // Need check, available check, tentative grant, scan, rollback on unsafe
    function automatic void check_request(int p);
        int np;
        int nr;
        np = procs_used();
        nr = res_used();
        for (int j = 0; j < nr; j++)
            if (req_buf[j] > need_q[p][j]) begin
                push_status(ST_OVER_NEED);
                return;
            end
        for (int j = 0; j < nr; j++)
            if (req_buf[j] > avail_q[j]) begin
                push_status(ST_OVER_AVAIL);
                return;
            end
        for (int j = 0; j < nr; j++) begin
            avail_q[j]    -= req_buf[j];
            alloc_q[p][j] += req_buf[j];
            need_q[p][j]  -= req_buf[j];
        end
        if (scan_safe(np, nr)) begin
            push_sequence(np);
            return;
        end
        for (int j = 0; j < nr; j++) begin
            avail_q[j]    += req_buf[j];
            alloc_q[p][j] -= req_buf[j];
            need_q[p][j]  += req_buf[j];
        end
        push_status(ST_UNSAFE);
    endfunction

    function automatic void predict_request(t_req r);
        case (r.operation)
            OP_LOAD_AVAIL: avail_q[r.resource_index] = r.amount;
            OP_LOAD_ALLOC: alloc_q[r.process_id][r.resource_index] = r.amount;
            OP_LOAD_NEED:  need_q[r.process_id][r.resource_index] = r.amount;
            OP_REQUEST: begin
                req_buf[r.resource_index] = r.amount;
                if (r.last_element) begin
                    check_request(r.process_id);
                    for (int j = 0; j < N_RES; j++) req_buf[j] = '0;
                end
            end
            OP_CHECK: begin
                if (scan_safe(procs_used(), res_used())) push_sequence(procs_used());
                else push_status(ST_UNSAFE);
            end
            default: ;
        endcase
    endfunction

    function automatic t_req mk_req(logic [2:0] op, int pid, int ri, int amt, bit last);
        t_req r;
        r.operation      = op;
        r.process_id     = 4'(pid);
        r.resource_index = 3'(ri);
        r.amount         = 16'(amt);
        r.last_element   = last;
        return r;
    endfunction

    function automatic void add_row(logic [2:0] op, int pid, int ri, int amt, bit last,
                                    bit typed = 0, logic [1:0] st = ST_OK);
        dir_rows.insert(dir_rows.size(),
                        t_row'{req: mk_req(op, pid, ri, amt, last), typed: typed, st: st});
    endfunction

    // Idle for a drawn gap, then drive one request; returns at the accepting edge
    task automatic send_req(t_req r, bit typed = 0, logic [1:0] st = ST_OK);
        int gap;
        int n_before;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        n_before = pending_rsp.size();
        predict_request(r);
        if (typed) begin
            while (pending_rsp.size() > n_before) void'(pending_rsp.pop_back());
            push_status(st);
        end
    endtask

    // Hold off until every result is in and the block is quiet
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_rsp.size() != 0 || busy);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [4:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PROC_COUNT) proc_cnt = val;
        else res_cnt = val[3:0];
        @(posedge i_clk);
    endtask

    function automatic int rand_amt();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 65535);
            1:       return 65535;
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_rsp);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result mismatch: exp %p got %p", want, o_rsp);
                end
            end
        end
    end

    // Watchdog: cycles without any request accepted or result seen
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("bankers_safety_allocator_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [4:0] pc_set[6];
        logic [4:0] rc_set[6];
        int         pid;
        int         n_elem;
        int         quota;
        int         sent;
        int         kind;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_PROC_COUNT;
        i_cfg_data  = '0;
        proc_cnt    = 5'd16;
        res_cnt     = 4'd8;
        for (int j = 0; j < N_RES; j++) begin
            avail_q[j] = '0;
            req_buf[j] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill both tables so no entry is read before it is written
        for (int p = 0; p < N_PROC; p++)
            for (int j = 0; j < N_RES; j++) begin
                send_req(mk_req(OP_LOAD_ALLOC, p, j, 0, 0));
                send_req(mk_req(OP_LOAD_NEED, p, j, 0, 0));
            end

        // Directed part
        add_row(OP_CHECK, 0, 0, 0, 0);
        add_row(OP_LOAD_NEED, 0, 0, 65535, 0);
        add_row(OP_REQUEST, 0, 0, 1, 1, 1, ST_OVER_AVAIL);
        add_row(OP_REQUEST, 1, 0, 1, 1, 1, ST_OVER_NEED);
        add_row(OP_CHECK, 0, 0, 0, 0, 1, ST_UNSAFE);
        add_row(OP_LOAD_AVAIL, 0, 0, 65535, 0);
        add_row(OP_CHECK, 0, 0, 0, 0);
        add_row(OP_LOAD_NEED, 0, 0, 10, 0);
        add_row(OP_LOAD_AVAIL, 0, 0, 5, 0);
        add_row(OP_LOAD_ALLOC, 3, 0, 65535, 0);
        add_row(OP_REQUEST, 0, 0, 5, 1);
        add_row(3'd5, 15, 7, 65535, 1);
        add_row(3'd6, 0, 0, 0, 0);
        add_row(3'd7, 9, 3, 21845, 1);
        // unsent-element check: r7 element exceeds a zero need
        add_row(OP_REQUEST, 0, 7, 3, 0);
        add_row(OP_REQUEST, 0, 0, 0, 1, 1, ST_OVER_NEED);
        add_row(OP_LOAD_NEED, 2, 1, 100, 0);
        add_row(OP_REQUEST, 0, 0, 0, 1, 1, ST_UNSAFE);
        add_row(OP_CHECK, 0, 0, 0, 0, 1, ST_UNSAFE);
        add_row(OP_LOAD_NEED, 2, 1, 0, 0);
        // allocation wrap on grant
        add_row(OP_LOAD_NEED, 3, 2, 1, 0);
        add_row(OP_LOAD_ALLOC, 3, 2, 65535, 0);
        add_row(OP_LOAD_AVAIL, 2, 1, 0, 0);
        add_row(OP_LOAD_AVAIL, 2, 2, 1, 0);
        add_row(OP_REQUEST, 3, 2, 1, 1);
        foreach (dir_rows[k]) send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].st);
        drain();

        // Random phases over several count settings, extremes and clamps included
        pc_set = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'($urandom_range(0, 31))};
        rc_set = '{5'd8, 5'd1, 5'd0, 5'd15, 5'd3, 5'($urandom_range(0, 15))};
        quota  = 8;
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_PROC_COUNT, pc_set[ph]);
            write_cfg(CFG_RES_COUNT, rc_set[ph]);
            sent = 0;
            while (sent < quota) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    send_req(mk_req(3'($urandom_range(0, 2)), $urandom_range(0, 15),
                                    $urandom_range(0, 7), rand_amt(), $urandom_range(0, 1)));
                    sent++;
                end else if (kind < 70) begin
                    pid    = $urandom_range(0, 15);
                    n_elem = $urandom_range(1, res_used());
                    for (int e = 0; e < n_elem; e++)
                        send_req(mk_req(OP_REQUEST, pid, $urandom_range(0, 7),
                                        ($urandom_range(0, 7) == 0) ? rand_amt()
                                                                    : $urandom_range(0, 4),
                                        e == n_elem - 1));
                    sent += n_elem;
                end else if (kind < 90) begin
                    send_req(mk_req(OP_CHECK, $urandom_range(0, 15), $urandom_range(0, 7),
                                    $urandom_range(0, 65535), $urandom_range(0, 1)));
                    sent++;
                end else begin
                    send_req(mk_req(3'($urandom_range(5, 7)), $urandom_range(0, 15),
                                    $urandom_range(0, 7), $urandom_range(0, 65535),
                                    $urandom_range(0, 1)));
                end
            end
            drain();
        end

        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("bankers_safety_allocator_top_tb OK");
        end else begin
            $display("bankers_safety_allocator_top_tb NOT OK");
        end
        $finish;
    end

endmodule
